// ===== design/burst_frequency_shift_gate_macros.svh =====
// Assertion macros used by the checker file.
`ifndef BURST_FREQUENCY_SHIFT_GATE_MACROS_SVH
`define BURST_FREQUENCY_SHIFT_GATE_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define BFSG_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define BFSG_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== design/bfsg_pkg.sv =====
// Package with shared types and constants of the burst frequency shift gate.
`timescale 1ns / 1ps
package bfsg_pkg;
    localparam int CORDIC_STAGES = 20;
    localparam int GUARD_BITS = 4;
    localparam int KINV_Q24 = 10188014;
    localparam int FREQ_W = 42;

    typedef enum logic [2:0] {
        REG_ROUND_FACTOR = 3'd0,
        REG_MIN_FREQ     = 3'd1,
        REG_MAX_FREQ     = 3'd2,
        REG_MAG_FLOOR    = 3'd3,
        REG_PAD_COUNT    = 3'd4
    } reg_idx_t;

    typedef enum logic {
        OP_HEADER = 1'b0,
        OP_SAMPLE = 1'b1
    } opcode_t;

    typedef enum logic [2:0] {
        HDR_IDLE,
        HDR_MUL,
        HDR_DIVQ,
        HDR_SHIFT,
        HDR_MOD,
        HDR_STEP,
        HDR_DONE
    } hdr_state_t;

    typedef logic [31:0] atan_t;

    function automatic atan_t atan_turn(input int idx);
        atan_t res;
        case (idx)
            0: res = 32'd536870912;
            1: res = 32'd316933406;
            2: res = 32'd167458907;
            3: res = 32'd85004757;
            4: res = 32'd42667331;
            5: res = 32'd21354465;
            6: res = 32'd10679838;
            7: res = 32'd5340245;
            8: res = 32'd2670163;
            9: res = 32'd1335087;
            10: res = 32'd667544;
            11: res = 32'd333772;
            12: res = 32'd166886;
            13: res = 32'd83443;
            14: res = 32'd41722;
            15: res = 32'd20861;
            16: res = 32'd10430;
            17: res = 32'd5215;
            18: res = 32'd2608;
            19: res = 32'd1304;
            default: res = 32'd0;
        endcase
        return res;
    endfunction
endpackage

// ===== design/bfsg_front.sv =====
// Front end: header arithmetic by serial division and queue of classified beats.
`timescale 1ns / 1ps
module bfsg_front
    import bfsg_pkg::*;
#(
    parameter int PHASE_BITS = 32,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_opcode,
    input  logic signed [31:0]            s_rel_freq,
    input  logic [39:0]                   s_center_freq_hz,
    input  logic [31:0]                   s_sample_rate_hz,
    input  logic signed [31:0]            s_burst_magnitude,
    input  logic [63:0]                   s_burst_id,
    input  logic signed [SAMPLE_BITS-1:0] s_sample_i,
    input  logic signed [SAMPLE_BITS-1:0] s_sample_q,
    input  logic                          s_last_sample,
    input  logic [31:0]                   round_factor,
    input  logic [39:0]                   min_freq,
    input  logic [39:0]                   max_freq,
    input  logic signed [31:0]            mag_floor,
    output logic                          q_valid,
    input  logic                          q_ready,
    output logic                          q_is_hdr,
    output logic                          q_accept,
    output logic [PHASE_BITS-1:0]         q_step,
    output logic [63:0]                   q_id,
    output logic signed [FREQ_W-1:0]      q_freq,
    output logic signed [SAMPLE_BITS-1:0] q_si,
    output logic signed [SAMPLE_BITS-1:0] q_sq,
    output logic                          q_last
);
    localparam int QW = 1 + 1 + PHASE_BITS + 64 + FREQ_W + 2 * SAMPLE_BITS + 1;
    localparam int QD = 4;
    localparam int CNT_W = 7;

    hdr_state_t state_reg, state_next;
    logic [63:0] num_reg;
    logic [95:0] den_reg;
    logic [63:0] quo_reg;
    logic [63:0] rem_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic neg_reg;
    logic [31:0] factor_reg, rate_reg;
    logic [39:0] center_reg;
    logic signed [31:0] mag_reg;
    logic [63:0] id_reg;
    logic signed [FREQ_W-1:0] freq_reg;
    logic [PHASE_BITS-1:0] step_reg;
    logic [63:0] shift_abs_reg;
    logic [31:0] prod_reg;

    logic [QW-1:0] fifo_mem [QD];
    logic [1:0] wr_ptr_reg, rd_ptr_reg;
    logic [2:0] fill_reg;
    logic push, pop;
    logic [QW-1:0] push_data;
    logic hdr_push;
    logic [QW-1:0] hdr_data, smp_data;

    logic [31:0] abs_rel;
    logic [64:0] rem_sh;
    logic [32:0] mrem_sh;
    logic signed [FREQ_W+1:0] freq_calc;
    logic hdr_ok;
    logic [31:0] m_fin;
    logic [63:0] mul_prod;
    logic [32:0] quo_rnd;
    logic [63:0] shift_prod;

    assign abs_rel = s_rel_freq[31] ? (32'd0 - s_rel_freq) : s_rel_freq;
    assign s_ready = (state_reg == HDR_IDLE) && (fill_reg < 3'(QD));

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            HDR_IDLE: if (s_valid && s_ready && s_opcode == OP_HEADER) state_next = HDR_MUL;
            HDR_MUL: state_next = HDR_DIVQ;
            HDR_DIVQ: if (cnt_reg == '0) state_next = HDR_SHIFT;
            HDR_SHIFT: state_next = HDR_MOD;
            HDR_MOD: if (cnt_reg == '0) state_next = HDR_STEP;
            HDR_STEP: if (cnt_reg == '0) state_next = HDR_DONE;
            HDR_DONE: if (fill_reg < 3'(QD)) state_next = HDR_IDLE;
            default: state_next = HDR_IDLE;
        endcase
    end

    // Restoring division helpers.
    assign rem_sh = {rem_reg, num_reg[63]};
    assign mrem_sh = {rem_reg[31:0], 1'b0};
    assign m_fin = rem_reg[31:0];
    assign mul_prod = {32'd0, prod_reg} * {32'd0, rate_reg};
    // Round half away from zero on the magnitude; the quotient fits in 33 bits.
    assign quo_rnd = 33'(quo_reg + {63'd0, rem_reg >= den_reg[63:0] - rem_reg});
    assign shift_prod = {31'd0, quo_rnd} * {32'd0, factor_reg};
    assign freq_calc = $signed({4'd0, center_reg})
        + (neg_reg ? -$signed({2'b00, shift_abs_reg[41:0]})
                   : $signed({2'b00, shift_abs_reg[41:0]}));
    assign hdr_ok = !(freq_reg < $signed({2'b00, min_freq})
        || freq_reg > $signed({2'b00, max_freq}) || mag_reg < mag_floor);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= HDR_IDLE;
        end else begin
            state_reg <= state_next;
        end
        case (state_reg)
            HDR_IDLE: begin
                neg_reg <= s_rel_freq[31];
                prod_reg <= abs_rel;
                rate_reg <= s_sample_rate_hz;
                factor_reg <= (round_factor == 32'd0) ? 32'd1 : round_factor;
                center_reg <= s_center_freq_hz;
                mag_reg <= s_burst_magnitude;
                id_reg <= s_burst_id;
            end
            HDR_MUL: begin
                num_reg <= mul_prod;
                den_reg <= {33'd0, factor_reg, 31'd0};
                rem_reg <= '0;
                quo_reg <= '0;
                cnt_reg <= CNT_W'(64);
            end
            HDR_DIVQ: begin
                if (cnt_reg != '0) begin
                    num_reg <= num_reg << 1;
                    if ({31'd0, rem_sh} >= den_reg) begin
                        rem_reg <= 64'(rem_sh - den_reg[64:0]);
                        quo_reg <= {quo_reg[62:0], 1'b1};
                    end else begin
                        rem_reg <= rem_sh[63:0];
                        quo_reg <= {quo_reg[62:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
            HDR_SHIFT: begin
                shift_abs_reg <= shift_prod;
                // Seed the reduction modulo rate with the shift magnitude.
                num_reg <= shift_prod;
                rem_reg <= '0;
                cnt_reg <= CNT_W'(64);
            end
            HDR_MOD: begin
                if (cnt_reg == CNT_W'(64))
                    freq_reg <= FREQ_W'(freq_calc);
                if (cnt_reg != '0) begin
                    num_reg <= num_reg << 1;
                    if (rem_sh >= {33'd0, rate_reg})
                        rem_reg <= 64'(rem_sh - {33'd0, rate_reg});
                    else
                        rem_reg <= rem_sh[63:0];
                    cnt_reg <= cnt_reg - 1'b1;
                end else begin
                    if (neg_reg && rem_reg != '0)
                        rem_reg <= {32'd0, rate_reg} - rem_reg;
                    step_reg <= '0;
                    cnt_reg <= CNT_W'(PHASE_BITS);
                end
            end
            HDR_STEP: begin
                if (cnt_reg != '0) begin
                    if (mrem_sh >= {1'b0, rate_reg}) begin
                        rem_reg <= {32'd0, 32'(mrem_sh - {1'b0, rate_reg})};
                        step_reg <= {step_reg[PHASE_BITS-2:0], 1'b1};
                    end else begin
                        rem_reg <= {32'd0, mrem_sh[31:0]};
                        step_reg <= {step_reg[PHASE_BITS-2:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg - 1'b1;
                end else begin
                    if (rate_reg == '0)
                        step_reg <= '0;
                    else if ({m_fin, 1'b0} >= {1'b0, rate_reg})
                        step_reg <= step_reg + 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign hdr_push = (state_reg == HDR_DONE) && (fill_reg < 3'(QD));
    assign hdr_data = {1'b1, hdr_ok, step_reg, id_reg, freq_reg,
                       {(2 * SAMPLE_BITS + 1){1'b0}}};
    assign smp_data = {1'b0, 1'b0, {PHASE_BITS{1'b0}}, 64'd0, {FREQ_W{1'b0}},
                       s_sample_i, s_sample_q, s_last_sample};
    assign push = hdr_push || (s_valid && s_ready && s_opcode == OP_SAMPLE);
    assign push_data = hdr_push ? hdr_data : smp_data;
    assign pop = q_valid && q_ready;
    assign q_valid = fill_reg != 3'd0;
    assign {q_is_hdr, q_accept, q_step, q_id, q_freq, q_si, q_sq, q_last} =
        fifo_mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) fifo_mem[wr_ptr_reg] <= push_data;
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop) rd_ptr_reg <= rd_ptr_reg + 1'b1;
            fill_reg <= fill_reg + 3'(push) - 3'(pop);
        end
    end
endmodule

// ===== design/bfsg_back.sv =====
// Back end: burst state, pipelined CORDIC mixer, padding and output register.
`timescale 1ns / 1ps
module bfsg_back
    import bfsg_pkg::*;
#(
    parameter int PHASE_BITS = 32,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_valid,
    output logic                          q_ready,
    input  logic                          q_is_hdr,
    input  logic                          q_accept,
    input  logic [PHASE_BITS-1:0]         q_step,
    input  logic [63:0]                   q_id,
    input  logic signed [FREQ_W-1:0]      q_freq,
    input  logic signed [SAMPLE_BITS-1:0] q_si,
    input  logic signed [SAMPLE_BITS-1:0] q_sq,
    input  logic                          q_last,
    input  logic [5:0]                    pad_count,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [SAMPLE_BITS-1:0] m_out_i,
    output logic signed [SAMPLE_BITS-1:0] m_out_q,
    output logic                          m_is_padding,
    output logic                          m_burst_start,
    output logic                          m_burst_end,
    output logic [63:0]                   m_tag_id,
    output logic signed [FREQ_W-1:0]      m_tag_freq_hz,
    output logic                          m_run_last
);
    localparam int XW = SAMPLE_BITS + GUARD_BITS + 3;
    localparam int NS = CORDIC_STAGES + 2;
    localparam int PW = XW + 25;

    logic accepted_reg, start_reg;
    logic [PHASE_BITS-1:0] phase_reg, step_reg;
    logic [63:0] id_reg;
    logic signed [FREQ_W-1:0] freq_reg;
    logic [5:0] pad_left_reg;
    logic busy_reg;

    logic signed [XW-1:0] x_reg [NS];
    logic signed [XW-1:0] y_reg [NS];
    logic signed [32:0] z_reg [NS];
    logic [NS-1:0] v_reg;
    logic [3:0] meta_reg [NS];
    logic [63:0] pid_reg [NS];
    logic signed [FREQ_W-1:0] pfreq_reg [NS];

    logic signed [PW-1:0] pi_reg, pq_reg;
    logic pv_reg;
    logic [3:0] pmeta_reg;
    logic [63:0] ppid_reg;
    logic signed [FREQ_W-1:0] ppfreq_reg;

    logic advance;
    logic [31:0] a32;
    logic signed [32:0] z0;
    logic smp_go, pad_go, n_last;
    logic signed [XW-1:0] xi, yi;
    logic signed [PW-1:0] ri, rq;
    logic signed [SAMPLE_BITS-1:0] si_sat, sq_sat;
    logic in_flight;

    function automatic logic signed [SAMPLE_BITS-1:0] sat(input logic signed [PW-1:0] v);
        logic signed [PW-1:0] hi;
        logic signed [PW-1:0] lo;
        hi = PW'((1 << (SAMPLE_BITS - 1)) - 1);
        lo = -hi - 1;
        if (v > hi) return hi[SAMPLE_BITS-1:0];
        if (v < lo) return lo[SAMPLE_BITS-1:0];
        return v[SAMPLE_BITS-1:0];
    endfunction

    // The pipeline only runs when the output register is free, so a whole
    // stall freezes it; beats are never lost.
    assign in_flight = (|v_reg) || pv_reg;
    assign advance = !m_valid || m_ready;
    assign q_ready = advance && !busy_reg && !(q_is_hdr && in_flight);
    assign smp_go = q_valid && q_ready && !q_is_hdr && accepted_reg;
    assign pad_go = advance && busy_reg;
    assign n_last = smp_go && q_last && pad_count != 6'd0;

    generate
        if (PHASE_BITS >= 32) begin : g_wide
            assign a32 = phase_reg[PHASE_BITS-1 -: 32];
        end else begin : g_narrow
            assign a32 = {phase_reg, {(32 - PHASE_BITS){1'b0}}};
        end
    endgenerate

    always_comb begin
        z0 = $signed({1'b0, 32'd0 - a32});
        z0 = {z0[31], z0[31:0]};
        xi = XW'(q_si) <<< GUARD_BITS;
        yi = XW'(q_sq) <<< GUARD_BITS;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            accepted_reg <= 1'b0;
            start_reg <= 1'b0;
            phase_reg <= '0;
            step_reg <= '0;
            id_reg <= '0;
            freq_reg <= '0;
            busy_reg <= 1'b0;
            pad_left_reg <= '0;
        end else begin
            if (q_valid && q_ready && q_is_hdr) begin
                phase_reg <= '0;
                step_reg <= q_step;
                accepted_reg <= q_accept;
                start_reg <= q_accept;
                if (q_accept) begin
                    id_reg <= q_id;
                    freq_reg <= q_freq;
                end
            end
            if (smp_go) begin
                start_reg <= 1'b0;
                phase_reg <= phase_reg + step_reg;
                if (q_last) accepted_reg <= 1'b0;
                if (n_last) begin
                    busy_reg <= 1'b1;
                    pad_left_reg <= pad_count;
                end
            end
            if (pad_go) begin
                pad_left_reg <= pad_left_reg - 1'b1;
                if (pad_left_reg == 6'd1) busy_reg <= 1'b0;
            end
        end
    end

    // Stage 0 holds the quadrant pre-rotation, stages 1 to NS-2 are CORDIC stages and stage NS-1 is a delay.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
            pv_reg <= 1'b0;
        end else if (advance) begin
            v_reg <= {v_reg[NS-2:0], smp_go || pad_go};
            pv_reg <= v_reg[NS-1];
        end
        if (advance) begin
            meta_reg[0] <= pad_go ? {1'b1, 1'b0, 1'b0, pad_left_reg == 6'd1}
                                  : {1'b0, start_reg, q_last, !(q_last && pad_count != 6'd0)};
            pid_reg[0] <= id_reg;
            pfreq_reg[0] <= freq_reg;
            if (pad_go) begin
                x_reg[0] <= '0;
                y_reg[0] <= '0;
                z_reg[0] <= '0;
            end else if (z0 > 33'sd1073741824) begin
                x_reg[0] <= -yi;
                y_reg[0] <= xi;
                z_reg[0] <= z0 - 33'sd1073741824;
            end else if (z0 < -33'sd1073741824) begin
                x_reg[0] <= yi;
                y_reg[0] <= -xi;
                z_reg[0] <= z0 + 33'sd1073741824;
            end else begin
                x_reg[0] <= xi;
                y_reg[0] <= yi;
                z_reg[0] <= z0;
            end
            for (int i = 1; i < NS - 1; i++) begin
                meta_reg[i] <= meta_reg[i-1];
                pid_reg[i] <= pid_reg[i-1];
                pfreq_reg[i] <= pfreq_reg[i-1];
                if (z_reg[i-1] >= 0) begin
                    x_reg[i] <= x_reg[i-1] - (y_reg[i-1] >>> (i - 1));
                    y_reg[i] <= y_reg[i-1] + (x_reg[i-1] >>> (i - 1));
                    z_reg[i] <= z_reg[i-1] - $signed({1'b0, atan_turn(i - 1)});
                end else begin
                    x_reg[i] <= x_reg[i-1] + (y_reg[i-1] >>> (i - 1));
                    y_reg[i] <= y_reg[i-1] - (x_reg[i-1] >>> (i - 1));
                    z_reg[i] <= z_reg[i-1] + $signed({1'b0, atan_turn(i - 1)});
                end
            end
            meta_reg[NS-1] <= meta_reg[NS-2];
            pid_reg[NS-1] <= pid_reg[NS-2];
            pfreq_reg[NS-1] <= pfreq_reg[NS-2];
            x_reg[NS-1] <= x_reg[NS-2];
            y_reg[NS-1] <= y_reg[NS-2];
            z_reg[NS-1] <= z_reg[NS-2];
            pi_reg <= PW'(x_reg[NS-1]) * PW'(KINV_Q24);
            pq_reg <= PW'(y_reg[NS-1]) * PW'(KINV_Q24);
            pmeta_reg <= meta_reg[NS-1];
            ppid_reg <= pid_reg[NS-1];
            ppfreq_reg <= pfreq_reg[NS-1];
        end
    end

    assign ri = (pi_reg + PW'(1 << (23 + GUARD_BITS))) >>> (24 + GUARD_BITS);
    assign rq = (pq_reg + PW'(1 << (23 + GUARD_BITS))) >>> (24 + GUARD_BITS);
    assign si_sat = sat(ri);
    assign sq_sat = sat(rq);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (advance) begin
            m_valid <= pv_reg;
        end
        if (advance) begin
            m_out_i <= si_sat;
            m_out_q <= sq_sat;
            {m_is_padding, m_burst_start, m_burst_end, m_run_last} <= pmeta_reg;
            m_tag_id <= ppid_reg;
            m_tag_freq_hz <= ppfreq_reg;
        end
    end
endmodule

// ===== design/burst_frequency_shift_gate.sv =====
// Path: a sample beat passes the front queue, the pipeline stages, the product and output registers.
// Throughput: one sample beat per cycle; padding beats one per cycle, while the output is not stalled.
// A header holds the input through the multiply and 64 + 64 + PHASE_BITS divider steps until queued.
// The front queue of four beats lets samples queue behind a finishing header.
// Reset: synchronous active-low aresetn clears control state and the configuration registers.
`timescale 1ns / 1ps
module burst_frequency_shift_gate
    import bfsg_pkg::*;
#(
    parameter int PHASE_BITS = 32,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [2:0]                    cfg_index,
    input  logic [39:0]                   cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_opcode,
    input  logic signed [31:0]            s_rel_freq,
    input  logic [39:0]                   s_center_freq_hz,
    input  logic [31:0]                   s_sample_rate_hz,
    input  logic signed [31:0]            s_burst_magnitude,
    input  logic [63:0]                   s_burst_id,
    input  logic signed [SAMPLE_BITS-1:0] s_sample_i,
    input  logic signed [SAMPLE_BITS-1:0] s_sample_q,
    input  logic                          s_last_sample,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [SAMPLE_BITS-1:0] m_out_i,
    output logic signed [SAMPLE_BITS-1:0] m_out_q,
    output logic                          m_is_padding,
    output logic                          m_burst_start,
    output logic                          m_burst_end,
    output logic [63:0]                   m_tag_id,
    output logic signed [FREQ_W-1:0]      m_tag_freq_hz,
    output logic                          m_run_last
);
    logic [31:0] round_factor_reg;
    logic [39:0] min_freq_reg, max_freq_reg;
    logic signed [31:0] mag_floor_reg;
    logic [5:0] pad_count_reg;

    logic q_valid, q_ready, q_is_hdr, q_accept, q_last;
    logic [PHASE_BITS-1:0] q_step;
    logic [63:0] q_id;
    logic signed [FREQ_W-1:0] q_freq;
    logic signed [SAMPLE_BITS-1:0] q_si, q_sq;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            round_factor_reg <= 32'd1;
            min_freq_reg <= '0;
            max_freq_reg <= 40'd1000000000000;
            mag_floor_reg <= 32'sh80000000;
            pad_count_reg <= '0;
        end else if (cfg_we) begin
            case (reg_idx_t'(cfg_index))
                REG_ROUND_FACTOR: round_factor_reg <= cfg_data[31:0];
                REG_MIN_FREQ: min_freq_reg <= cfg_data;
                REG_MAX_FREQ: max_freq_reg <= cfg_data;
                REG_MAG_FLOOR: mag_floor_reg <= cfg_data[31:0];
                REG_PAD_COUNT: pad_count_reg <= cfg_data[5:0];
                default: ;
            endcase
        end
    end

    bfsg_front #(.PHASE_BITS(PHASE_BITS), .SAMPLE_BITS(SAMPLE_BITS)) u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_opcode, .s_rel_freq,
        .s_center_freq_hz, .s_sample_rate_hz, .s_burst_magnitude, .s_burst_id,
        .s_sample_i, .s_sample_q, .s_last_sample,
        .round_factor(round_factor_reg), .min_freq(min_freq_reg),
        .max_freq(max_freq_reg), .mag_floor(mag_floor_reg),
        .q_valid, .q_ready, .q_is_hdr, .q_accept, .q_step, .q_id, .q_freq,
        .q_si, .q_sq, .q_last
    );

    bfsg_back #(.PHASE_BITS(PHASE_BITS), .SAMPLE_BITS(SAMPLE_BITS)) u_back (
        .aclk, .aresetn, .q_valid, .q_ready, .q_is_hdr, .q_accept, .q_step,
        .q_id, .q_freq, .q_si, .q_sq, .q_last, .pad_count(pad_count_reg),
        .m_valid, .m_ready, .m_out_i, .m_out_q, .m_is_padding, .m_burst_start,
        .m_burst_end, .m_tag_id, .m_tag_freq_hz, .m_run_last
    );
endmodule

// ===== design/bfsg_checker.sv =====
// Port-level checker for the burst frequency shift gate, bound to the top level.
`timescale 1ns / 1ps
`include "burst_frequency_shift_gate_macros.svh"
module bfsg_checker
    import bfsg_pkg::*;
#(
    parameter int SAMPLE_BITS = 16
) (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic signed [SAMPLE_BITS-1:0] m_out_i,
    input logic signed [SAMPLE_BITS-1:0] m_out_q,
    input logic                          m_is_padding,
    input logic                          m_burst_start,
    input logic                          m_burst_end
);
    `BFSG_ASSERT_IMPL(a_pad_zero, aclk, aresetn, m_valid && m_is_padding,
        m_out_i == '0 && m_out_q == '0 && !m_burst_start && !m_burst_end,
        "Padding beat carries data or flags.")
    `BFSG_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_out_i) && $stable(m_out_q),
        "Stalled result beat changed.")
    `BFSG_ASSERT_NEXT(a_pad_after_end, aclk, aresetn,
        m_valid && m_ready && m_burst_start && !m_burst_end,
        !(m_valid && m_is_padding), "Padding directly after a burst start.")
endmodule

bind burst_frequency_shift_gate bfsg_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_bfsg_checker (
    .aclk, .aresetn, .m_valid, .m_ready, .m_out_i, .m_out_q, .m_is_padding,
    .m_burst_start, .m_burst_end
);

// ===== test/burst_frequency_shift_gate_tb.sv =====
// Self-checking testbench for the burst frequency shift gate: header gating, mixing, padding.
`timescale 1ns / 1ps
module burst_frequency_shift_gate_tb;
    import bfsg_pkg::*;

    localparam int SW = 16;
    localparam int PW = 32;
    localparam int STALL_LIMIT = 20000;

    typedef struct packed {
        logic signed [SW-1:0] out_i;
        logic signed [SW-1:0] out_q;
        logic                 is_padding;
        logic                 burst_start;
        logic                 burst_end;
        logic [63:0]          tag_id;
        logic [FREQ_W-1:0]    tag_freq;
        logic                 run_last;
    } mix_beat_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [2:0] cfg_index = '0;
    logic [39:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_opcode = 1'b0;
    logic signed [31:0] s_rel_freq = '0;
    logic [39:0] s_center_freq_hz = '0;
    logic [31:0] s_sample_rate_hz = '0;
    logic signed [31:0] s_burst_magnitude = '0;
    logic [63:0] s_burst_id = '0;
    logic signed [SW-1:0] s_sample_i = '0;
    logic signed [SW-1:0] s_sample_q = '0;
    logic s_last_sample = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [SW-1:0] m_out_i;
    logic signed [SW-1:0] m_out_q;
    logic m_is_padding;
    logic m_burst_start;
    logic m_burst_end;
    logic [63:0] m_tag_id;
    logic signed [FREQ_W-1:0] m_tag_freq_hz;
    logic m_run_last;

    always #1 aclk = ~aclk;

    burst_frequency_shift_gate u_dut (.*);

    // Predictor state and configuration.
    logic [31:0] round_factor;
    logic [39:0] min_freq, max_freq;
    logic signed [31:0] mag_floor;
    logic [5:0] pad_count;
    logic burst_open, start_pending;
    logic [PW-1:0] phase_acc, phase_step;
    logic [63:0] cur_id;
    logic signed [63:0] cur_freq;

    mix_beat_t expected_beats[$];
    int errors = 0;
    int beats_seen = 0;
    int items_sent = 0;
    int stall_cycles = 0;
    bit out_stall_enable = 1'b1;
    bit in_gap_enable = 1'b1;

    function automatic longint sra(longint v, int s);
        return v >>> s;
    endfunction

    function automatic void rotate(input longint si, input longint sq,
                                   output longint oi, output longint oq);
        longint x, y, z, t, dx, dy, rnd;
        logic [31:0] neg;
        neg = 32'd0 - phase_acc[PW-1:PW-32];
        z = longint'(signed'(neg));
        x = si * 16;
        y = sq * 16;
        if (z > (64'sd1 << 30)) begin
            t = x; x = -y; y = t; z -= (64'sd1 << 30);
        end else if (z < -(64'sd1 << 30)) begin
            t = x; x = y; y = -t; z += (64'sd1 << 30);
        end
        for (int i = 0; i < CORDIC_STAGES; i++) begin
            dx = sra(y, i);
            dy = sra(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(atan_turn(i));
            end else begin
                x += dx; y -= dy; z += longint'(atan_turn(i));
            end
        end
        rnd = 64'sd1 << 27;
        oi = sra(x * KINV_Q24 + rnd, 28);
        oq = sra(y * KINV_Q24 + rnd, 28);
        if (oi > 32767) oi = 32767;
        if (oi < -32768) oi = -32768;
        if (oq > 32767) oq = 32767;
        if (oq < -32768) oq = -32768;
    endfunction

    function automatic void predict_header(logic signed [31:0] rel, logic [39:0] center,
                                           logic [31:0] rate, logic signed [31:0] mag,
                                           logic [63:0] id);
        logic [63:0] factor, absn, den, q, r, m, st;
        longint shift, freq;
        factor = (round_factor == 0) ? 64'd1 : 64'(round_factor);
        absn = 64'(rel < 0 ? -longint'(rel) : longint'(rel)) * 64'(rate);
        den = factor << 31;
        q = absn / den;
        r = absn % den;
        if (r >= den - r) q++;
        shift = longint'(q * factor);
        if (rel < 0) shift = -shift;
        freq = longint'(center) + shift;
        phase_acc = '0;
        phase_step = '0;
        if (rate != 0) begin
            m = 64'(shift < 0 ? -shift : shift) % 64'(rate);
            st = 0;
            if (shift < 0 && m != 0) m = 64'(rate) - m;
            for (int b = 0; b < PW; b++) begin
                m <<= 1; st <<= 1;
                if (m >= 64'(rate)) begin
                    m -= 64'(rate); st |= 1;
                end
            end
            if ((m << 1) >= 64'(rate)) st++;
            phase_step = st[PW-1:0];
        end
        burst_open = !(freq < longint'(min_freq) || freq > longint'(max_freq)
                       || mag < mag_floor);
        start_pending = burst_open;
        if (burst_open) begin
            cur_id = id;
            cur_freq = freq;
        end
    endfunction

    function automatic void predict_sample(logic signed [SW-1:0] si, logic signed [SW-1:0] sq,
                                           logic last);
        mix_beat_t b;
        longint oi, oq;
        int n;
        if (!burst_open) return;
        n = last ? int'(pad_count) : 0;
        rotate(longint'(si), longint'(sq), oi, oq);
        b.out_i = oi[SW-1:0];
        b.out_q = oq[SW-1:0];
        b.is_padding = 1'b0;
        b.burst_start = start_pending;
        b.burst_end = last;
        b.tag_id = cur_id;
        b.tag_freq = cur_freq[FREQ_W-1:0];
        b.run_last = (n == 0);
        expected_beats.insert(expected_beats.size(), b);
        start_pending = 1'b0;
        phase_acc = phase_acc + phase_step;
        for (int k = 1; k <= n; k++) begin
            b.out_i = '0;
            b.out_q = '0;
            b.is_padding = 1'b1;
            b.burst_start = 1'b0;
            b.burst_end = 1'b0;
            b.run_last = (k == n);
            expected_beats.insert(expected_beats.size(), b);
        end
        if (last) burst_open = 1'b0;
    endfunction

    task automatic send_item(logic op, logic signed [31:0] rel, logic [39:0] center,
                             logic [31:0] rate, logic signed [31:0] mag, logic [63:0] id,
                             logic signed [SW-1:0] si, logic signed [SW-1:0] sq, logic last);
        int gap;
        gap = in_gap_enable ? $urandom_range(0, 15) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_opcode <= op;
        s_rel_freq <= rel;
        s_center_freq_hz <= center;
        s_sample_rate_hz <= rate;
        s_burst_magnitude <= mag;
        s_burst_id <= id;
        s_sample_i <= si;
        s_sample_q <= sq;
        s_last_sample <= last;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        if (op == OP_HEADER) predict_header(rel, center, rate, mag, id);
        else predict_sample(si, sq, last);
    endtask

    task automatic send_header(logic signed [31:0] rel, logic [39:0] center,
                               logic [31:0] rate, logic signed [31:0] mag, logic [63:0] id);
        send_item(OP_HEADER, rel, center, rate, mag, id,
                  SW'($urandom), SW'($urandom), 1'($urandom));
    endtask

    task automatic send_sample(logic signed [SW-1:0] si, logic signed [SW-1:0] sq,
                               logic last);
        send_item(OP_SAMPLE, 32'($urandom), {8'($urandom), 32'($urandom)}, $urandom,
                  $urandom, {$urandom, $urandom}, si, sq, last);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [39:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
        case (idx)
            REG_ROUND_FACTOR: round_factor = val[31:0];
            REG_MIN_FREQ:     min_freq = val;
            REG_MAX_FREQ:     max_freq = val;
            REG_MAG_FLOOR:    mag_floor = val[31:0];
            REG_PAD_COUNT:    pad_count = val[5:0];
            default: ;
        endcase
    endtask

    task automatic drain_and_settle();
        s_valid <= 1'b0;
        while (expected_beats.size() != 0) @(posedge aclk);
        // A header may still be in the serial divider with nothing expected.
        repeat (250) @(posedge aclk);
    endtask

    task automatic test_directed();
        send_header(32'sh7fffffff, 40'd1000000, 32'd48000, 32'sd0, 64'hffffffffffffffff);
        send_sample(16'sh7fff, 16'sh7fff, 1'b0);
        send_sample(-16'sh8000, -16'sh8000, 1'b0);
        send_sample(16'sh7fff, -16'sh8000, 1'b0);
        send_sample(16'sd0, 16'sd0, 1'b1);
        send_sample(16'sd100, 16'sd100, 1'b1);
        send_header(-32'sh80000000, 40'hffffffffff, 32'hffffffff, 32'sh7fffffff, 64'd0);
        send_sample(16'sd1234, -16'sd4321, 1'b1);
        send_header(32'sh40000000, 40'd5000000, 32'd0, -32'sh80000000, 64'h0123456789abcdef);
        send_sample(-16'sd1, 16'sd1, 1'b0);
        send_header(32'sh20000000, 40'd2000000, 32'd1000000, 32'sd10, 64'd7);
        send_sample(16'sh4000, 16'sh0, 1'b0);
        send_sample(16'sh4000, 16'sh0, 1'b0);
        send_header(-32'sh20000000, 40'd2000000, 32'd1000000, 32'sd10, 64'd8);
        send_sample(16'sh0, 16'sh4000, 1'b0);
        send_sample(16'sh0, 16'sh4000, 1'b1);
        send_header(32'sh1, 40'd1000000000001, 32'd10, 32'sd0, 64'd9);
        send_sample(16'sd5, 16'sd5, 1'b1);
        drain_and_settle();
    endtask

    task automatic test_config_extremes();
        write_reg(REG_ROUND_FACTOR, 40'd0);
        write_reg(REG_MIN_FREQ, 40'd1000);
        write_reg(REG_MAX_FREQ, 40'hffffffffff);
        write_reg(REG_MAG_FLOOR, 40'h007fffffff);
        write_reg(REG_PAD_COUNT, 40'd63);
        send_header(32'sh10000000, 40'd5000, 32'd1000, 32'sh7fffffff, 64'd11);
        send_sample(16'sd300, 16'sd300, 1'b1);
        send_header(32'sh10000000, 40'd5000, 32'd1000, 32'sh7ffffffe, 64'd12);
        send_sample(16'sd300, 16'sd300, 1'b1);
        drain_and_settle();
        write_reg(REG_ROUND_FACTOR, 40'hffffffff);
        write_reg(REG_MIN_FREQ, 40'd0);
        write_reg(REG_MAG_FLOOR, 40'h0080000000);
        write_reg(REG_PAD_COUNT, 40'd1);
        send_header(32'sh7fffffff, 40'd10, 32'hffffffff, 32'sd0, 64'd13);
        send_sample(16'sd300, -16'sd300, 1'b1);
        send_header(32'sh7fffffff, 40'd10, 32'd20, 32'sd0, 64'd14);
        send_sample(16'sd300, -16'sd300, 1'b1);
        drain_and_settle();
    endtask

    task automatic random_phase(int bursts);
        logic [31:0] rate;
        int len;
        for (int b = 0; b < bursts; b++) begin
            rate = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 2000000);
            send_header($urandom, $urandom_range(0, 3) == 0 ? {8'($urandom), $urandom}
                                                          : 40'($urandom_range(0, 400000000)),
                        rate, $urandom_range(0, 7) == 0 ? $urandom : $urandom_range(0, 5000),
                        {$urandom, $urandom});
            len = $urandom_range(1, 8);
            for (int k = 0; k < len; k++)
                send_sample(SW'($urandom), SW'($urandom),
                            (k == len - 1) && ($urandom_range(0, 7) != 0));
            if ($urandom_range(0, 5) == 0)
                send_sample(SW'($urandom), SW'($urandom), 1'($urandom));
        end
        drain_and_settle();
    endtask

    task automatic test_random();
        write_reg(REG_ROUND_FACTOR, 40'd1);
        write_reg(REG_MIN_FREQ, 40'd1000000);
        write_reg(REG_MAX_FREQ, 40'd300000000);
        write_reg(REG_MAG_FLOOR, 40'd100);
        write_reg(REG_PAD_COUNT, 40'd0);
        random_phase(12);
        write_reg(REG_ROUND_FACTOR, 40'd1000);
        write_reg(REG_PAD_COUNT, 40'd3);
        write_reg(REG_MAG_FLOOR, 40'hff80000000);
        random_phase(12);
        in_gap_enable = 1'b0;
        out_stall_enable = 1'b0;
        write_reg(REG_MIN_FREQ, 40'd0);
        write_reg(REG_MAX_FREQ, 40'hffffffffff);
        write_reg(REG_ROUND_FACTOR, 40'd7);
        write_reg(REG_PAD_COUNT, 40'd2);
        random_phase(8);
        in_gap_enable = 1'b1;
        out_stall_enable = 1'b1;
        random_phase(8);
    endtask

    // Result checker and output stalls.
    always @(posedge aclk) begin
        mix_beat_t got, want;
        if (aresetn && m_valid && m_ready) begin
            got = {m_out_i, m_out_q, m_is_padding, m_burst_start, m_burst_end,
                   m_tag_id, m_tag_freq_hz, m_run_last};
            beats_seen++;
            if (expected_beats.size() == 0) begin
                $display("%0t: unexpected beat, expected none, actual %h", $time, got);
                errors++;
            end else begin
                want = expected_beats[0];
                expected_beats.delete(0);
                if (got !== want) begin
                    $display("%0t: beat mismatch, expected %p, actual %p", $time, want, got);
                    errors++;
                end
            end
        end
    end

    initial begin
        int wait_left;
        wait_left = 0;
        forever begin
            @(posedge aclk);
            if (!out_stall_enable) m_ready <= 1'b1;
            else if (wait_left > 0) begin
                wait_left--;
                m_ready <= (wait_left == 0);
            end else if (m_valid && m_ready) begin
                wait_left = $urandom_range(0, 15);
                m_ready <= (wait_left == 0);
            end else m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_we) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        round_factor = 32'd1;
        min_freq = 40'd0;
        max_freq = 40'd1000000000000;
        mag_floor = -32'sh80000000;
        pad_count = '0;
        burst_open = 1'b0;
        start_pending = 1'b0;
        phase_acc = '0;
        phase_step = '0;
        cur_id = '0;
        cur_freq = '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_config_extremes();
        test_random();
        $display("Covered %0d input items and %0d output beats over several register settings.",
                 items_sent, beats_seen);
        if (errors == 0 && expected_beats.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+design
design/bfsg_pkg.sv
design/bfsg_front.sv
design/bfsg_back.sv
design/burst_frequency_shift_gate.sv
design/bfsg_checker.sv
test/burst_frequency_shift_gate_tb.sv
